### design/tlsd_pkg.sv
// Shared types and constants for the TLS record deframer.
// No dependencies; used by tlsd_rsp_fifo and tls_record_deframer.
package tlsd_pkg;

   localparam int OFS_W = 16;

   localparam logic [15:0] MAX_REC_RESET = 16'((1 << 14) + 256);

   // record content types
   localparam logic [7:0] CT_CCS       = 8'd20;
   localparam logic [7:0] CT_HANDSHAKE = 8'd22;
   localparam logic [7:0] CT_HEARTBEAT = 8'd24;
   localparam logic [7:0] VER_MAJOR    = 8'h03;

   // result status codes
   localparam logic [2:0] ST_RECORD     = 3'd0;
   localparam logic [2:0] ST_HS_MSG     = 3'd1;
   localparam logic [2:0] ST_MALFORMED  = 3'd2;
   localparam logic [2:0] ST_BAD_PAY    = 3'd3;
   localparam logic [2:0] ST_PARTIAL    = 3'd4;
   localparam logic [2:0] ST_HS_PENDING = 3'd5;

   localparam logic [2:0] HDR_LAST    = 3'd4;   // index of fifth record header byte
   localparam logic [2:0] HS_HDR_LAST = 3'd3;   // index of last handshake header byte

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic [2:0]       status;
      logic [7:0]       rec_kind;
      logic [15:0]      record_version;
      logic [15:0]      payload_len;
      logic [7:0]       msg_kind;
      logic [23:0]      msg_len;
      logic             reassembled;
      logic [OFS_W-1:0] consumed_offset;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    item0;
      rsp_type    item1;
   } push_type;

   function automatic rsp_type mk_rsp(input logic [2:0] st, input logic with_rec,
                                      input logic [7:0] ct, input logic [15:0] ver,
                                      input logic [15:0] len, input logic [7:0] ht,
                                      input logic [23:0] hl, input logic re,
                                      input logic [OFS_W-1:0] ofs);
      rsp_type r;
      r.status          = st;
      r.rec_kind        = with_rec ? ct : 8'd0;
      r.record_version  = with_rec ? ver : 16'd0;
      r.payload_len     = with_rec ? len : 16'd0;
      r.msg_kind        = ht;
      r.msg_len         = hl;
      r.reassembled     = re;
      r.consumed_offset = ofs;
      r.last            = 1'b0;
      return r;
   endfunction

endpackage

### design/tlsd_rsp_fifo.sv
// Small result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
// Depends on tlsd_pkg.
module tlsd_rsp_fifo import tlsd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_item
);

   rsp_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               pop;
   logic [FIFO_AW-1:0] wr_ptr_nxt;

   assign pop        = out_valid && out_ready;
   assign out_valid  = (count_ff != '0);
   assign out_item   = mem_ff[rd_ptr_ff];
   assign room       = (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
   assign wr_ptr_nxt = wr_ptr_ff + FIFO_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.cnt);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.cnt == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push.item1;
      end
   end

endmodule

### design/tls_record_deframer.sv
// TLS record deframer top level: header parse, handshake framing, checks.
// Depends on tlsd_pkg and tlsd_rsp_fifo.
//
//  channel | dir | payload                                         | handshake
//  req     | in  | tdata: data_byte; tlast: end_of_segment;        | tvalid/tready
//          |     | tuser: connection_start                         |
//  rsp     | out | tdata/tuser/tlast: one result per transfer      | tvalid/tready
//  csr     | in  | max_record_length                               | csr_we
//
// One request per cycle: each byte is parsed in the cycle it is accepted and
// its zero, one or two results land in a 4-entry queue that feeds rsp.
// req_tready drops only while fewer than two queue slots are free, i.e. when
// rsp stalls; a byte that yields two results drains them through rsp in turn.
// Synchronous reset clears the parser state, the ciphertext flag, the queue
// and reloads max_record_length with 16640.
module tls_record_deframer import tlsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // end_of_segment
   input  logic        req_tuser,    // connection_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] record type, [23:8] record_version, [39:24] record payload length,
   // [47:40] message type, [71:48] message length, [72] reassembled,
   // [88:73] consumed_offset, [95:89] zero
   output logic [95:0] rsp_tdata,
   output logic        rsp_tlast,    // last
   output logic [2:0]  rsp_tuser,    // [2:0] status
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0]      max_len_ff;
   logic [2:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]       rec_type_ff, rec_type_in;
   logic [15:0]      rec_version_ff, rec_version_in;
   logic [15:0]      rec_length_ff, rec_length_in;
   logic [15:0]      payload_left_ff, payload_left_in;
   logic [23:0]      payload_head_ff, payload_head_in;
   logic             cipher_ff, cipher_in;
   logic             halted_ff, halted_in;
   logic [OFS_W-1:0] seg_offset_ff, seg_offset_in;
   logic [OFS_W-1:0] safe_offset_ff, safe_offset_in;
   logic [2:0]       hs_hdr_cnt_ff, hs_hdr_cnt_in;
   logic [7:0]       hs_type_ff, hs_type_in;
   logic [23:0]      hs_left_ff, hs_left_in;
   logic [7:0]       hs_records_ff, hs_records_in;

   logic             req_acc;
   logic [7:0]       b;
   logic             fin;
   logic             msg_done;
   logic             framing_v;
   logic             bad_hdr;
   logic             bad_pay;
   logic [OFS_W-1:0] rec_end;
   logic [1:0]       n_v;
   rsp_type          res_v [2];
   push_type         push;
   logic             fifo_room;
   rsp_type          out_item;

   assign req_tready = fifo_room;
   assign req_acc    = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign rec_end    = seg_offset_ff + OFS_W'(1);

   always_comb begin
      hdr_cnt_in      = hdr_cnt_ff;
      rec_type_in     = rec_type_ff;
      rec_version_in  = rec_version_ff;
      rec_length_in   = rec_length_ff;
      payload_left_in = payload_left_ff;
      payload_head_in = payload_head_ff;
      cipher_in       = cipher_ff;
      halted_in       = halted_ff;
      safe_offset_in  = safe_offset_ff;
      hs_hdr_cnt_in   = hs_hdr_cnt_ff;
      hs_type_in      = hs_type_ff;
      hs_left_in      = hs_left_ff;
      hs_records_in   = hs_records_ff;
      fin             = 1'b0;
      msg_done        = 1'b0;
      framing_v       = 1'b0;
      bad_hdr         = 1'b0;
      bad_pay         = 1'b0;
      n_v             = 2'd0;
      res_v[0]        = '0;
      res_v[1]        = '0;

      if (req_tuser) begin
         cipher_in = 1'b0;
      end

      if (!halted_ff) begin
         if (payload_left_ff == 16'd0) begin
            case (hdr_cnt_ff)
               3'd0: begin
                  rec_type_in    = b;
                  rec_version_in = 16'd0;
                  rec_length_in  = 16'd0;
               end
               3'd1: rec_version_in = {b, 8'd0};
               3'd2: rec_version_in = {rec_version_ff[15:8], b};
               3'd3: rec_length_in  = {b, 8'd0};
               default: rec_length_in = {rec_length_ff[15:8], b};
            endcase
            if (hdr_cnt_ff != HDR_LAST) begin
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
            end else begin
               hdr_cnt_in = 3'd0;
               bad_hdr = (rec_type_in < CT_CCS) || (rec_type_in > CT_HEARTBEAT) ||
                         (rec_version_in[15:8] != VER_MAJOR) ||
                         (rec_length_in > max_len_ff);
               if (bad_hdr) begin
                  res_v[n_v[0]] = mk_rsp(ST_MALFORMED, 1'b1, rec_type_in, rec_version_in,
                                         rec_length_in, 8'd0, 24'd0, 1'b0, safe_offset_in);
                  n_v       = n_v + 2'd1;
                  halted_in = 1'b1;
               end else if ((rec_type_in != CT_HANDSHAKE || cipher_in) &&
                            hs_hdr_cnt_ff != 3'd0) begin
                  // non-handshake (or post-ChangeCipherSpec) record arrives while a message is open
                  res_v[n_v[0]] = mk_rsp(ST_HS_PENDING, 1'b1, rec_type_in, rec_version_in,
                                         rec_length_in, 8'd0, 24'd0, 1'b0, safe_offset_in);
                  n_v       = n_v + 2'd1;
                  halted_in = 1'b1;
               end else begin
                  payload_left_in = rec_length_in;
                  if (!(rec_type_in == CT_HANDSHAKE && !cipher_in)) begin
                     payload_head_in = 24'd0;
                  end
                  fin = (rec_length_in == 16'd0);
               end
            end
         end else begin
            if (rec_type_ff == CT_HANDSHAKE && !cipher_in) begin
               if (hs_hdr_cnt_ff == 3'd0) begin
                  hs_type_in    = b;
                  hs_left_in    = 24'd0;
                  hs_hdr_cnt_in = 3'd1;
               end else if (hs_hdr_cnt_ff <= HS_HDR_LAST) begin
                  hs_left_in    = {hs_left_ff[15:0], b};
                  hs_hdr_cnt_in = hs_hdr_cnt_ff + 3'd1;
                  if (hs_hdr_cnt_ff == HS_HDR_LAST) begin
                     payload_head_in = hs_left_in;
                     msg_done        = (hs_left_in == 24'd0);
                  end
               end else begin
                  hs_left_in = hs_left_ff - 24'd1;
                  msg_done   = (hs_left_in == 24'd0);
               end
               if (msg_done) begin
                  res_v[n_v[0]] = mk_rsp(ST_HS_MSG, 1'b1, rec_type_ff, rec_version_ff,
                                         rec_length_ff, hs_type_in, payload_head_in,
                                         hs_records_ff != 8'd0, safe_offset_in);
                  n_v           = n_v + 2'd1;
                  hs_hdr_cnt_in = 3'd0;
               end
            end else if ((rec_length_ff - payload_left_ff) < 16'd3) begin
               payload_head_in = {payload_head_ff[15:0], b};
            end
            payload_left_in = payload_left_ff - 16'd1;
            fin = (payload_left_in == 16'd0);
         end

         if (fin) begin
            framing_v = (rec_type_in == CT_HANDSHAKE) && !cipher_in;
            bad_pay = (rec_type_in == CT_CCS && rec_length_in == 16'd1 &&
                       payload_head_in[7:0] != 8'd1) ||
                      (rec_type_in == CT_HEARTBEAT && rec_length_in >= 16'd3 &&
                       payload_head_in[15:0] > (rec_length_in - 16'd3));
            if (framing_v) begin
               // a handshake record is safe only if it ends on a message boundary
               if (hs_hdr_cnt_in == 3'd0) begin
                  safe_offset_in = rec_end;
                  hs_records_in  = 8'd0;
               end else if (hs_records_in != 8'hff) begin
                  hs_records_in = hs_records_in + 8'd1;
               end
            end else if (bad_pay) begin
               halted_in = 1'b1;
            end else begin
               safe_offset_in = rec_end;
               if (rec_type_in == CT_CCS && rec_length_in == 16'd1) begin
                  cipher_in = 1'b1;
               end
            end
            if (n_v != 2'd2) begin
               res_v[n_v[0]] = mk_rsp((!framing_v && bad_pay) ? ST_BAD_PAY : ST_RECORD,
                                      1'b1, rec_type_in, rec_version_in, rec_length_in,
                                      8'd0, 24'd0, 1'b0, safe_offset_in);
               n_v = n_v + 2'd1;
            end
         end

         if (req_tlast && !halted_in) begin
            if ((hdr_cnt_in != 3'd0 || payload_left_in != 16'd0) && n_v != 2'd2) begin
               res_v[n_v[0]] = mk_rsp(ST_PARTIAL, payload_left_in != 16'd0, rec_type_in,
                                      rec_version_in, rec_length_in, 8'd0, 24'd0, 1'b0,
                                      safe_offset_in);
               n_v = n_v + 2'd1;
            end
            if (hs_hdr_cnt_in != 3'd0 && n_v != 2'd2) begin
               res_v[n_v[0]] = mk_rsp(ST_HS_PENDING, 1'b0, rec_type_in, rec_version_in,
                                      rec_length_in, 8'd0, 24'd0, 1'b0, safe_offset_in);
               n_v = n_v + 2'd1;
            end
         end
      end

      if (n_v == 2'd1) begin
         res_v[0].last = 1'b1;
      end else if (n_v == 2'd2) begin
         res_v[1].last = 1'b1;
      end

      if (req_tlast) begin
         hdr_cnt_in      = 3'd0;
         rec_type_in     = 8'd0;
         rec_version_in  = 16'd0;
         rec_length_in   = 16'd0;
         payload_left_in = 16'd0;
         payload_head_in = 24'd0;
         halted_in       = 1'b0;
         seg_offset_in   = '0;
         safe_offset_in  = '0;
         hs_hdr_cnt_in   = 3'd0;
         hs_type_in      = 8'd0;
         hs_left_in      = 24'd0;
         hs_records_in   = 8'd0;
      end else begin
         seg_offset_in = rec_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_REC_RESET;
      end else if (csr_we) begin
         max_len_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff      <= '0;
         rec_type_ff     <= '0;
         rec_version_ff  <= '0;
         rec_length_ff   <= '0;
         payload_left_ff <= '0;
         payload_head_ff <= '0;
         cipher_ff       <= 1'b0;
         halted_ff       <= 1'b0;
         seg_offset_ff   <= '0;
         safe_offset_ff  <= '0;
         hs_hdr_cnt_ff   <= '0;
         hs_type_ff      <= '0;
         hs_left_ff      <= '0;
         hs_records_ff   <= '0;
      end else if (req_acc) begin
         hdr_cnt_ff      <= hdr_cnt_in;
         rec_type_ff     <= rec_type_in;
         rec_version_ff  <= rec_version_in;
         rec_length_ff   <= rec_length_in;
         payload_left_ff <= payload_left_in;
         payload_head_ff <= payload_head_in;
         cipher_ff       <= cipher_in;
         halted_ff       <= halted_in;
         seg_offset_ff   <= seg_offset_in;
         safe_offset_ff  <= safe_offset_in;
         hs_hdr_cnt_ff   <= hs_hdr_cnt_in;
         hs_type_ff      <= hs_type_in;
         hs_left_ff      <= hs_left_in;
         hs_records_ff   <= hs_records_in;
      end
   end

   always_comb begin
      push.cnt   = req_acc ? n_v : 2'd0;
      push.item0 = res_v[0];
      push.item1 = res_v[1];
   end

   tlsd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (fifo_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tuser = out_item.status;
   assign rsp_tlast = out_item.last;
   assign rsp_tdata = {7'd0, out_item.consumed_offset, out_item.reassembled,
                       out_item.msg_len, out_item.msg_kind,
                       out_item.payload_len, out_item.record_version,
                       out_item.rec_kind};

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      (req_acc && halted_ff) |-> (push.cnt == 2'd0))
      else $error("result produced while segment halted");

   a_seg_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tlast) |=> (seg_offset_ff == '0 && hdr_cnt_ff == 3'd0 &&
                                  payload_left_ff == 16'd0 && hs_hdr_cnt_ff == 3'd0))
      else $error("segment state not cleared after end of segment");

   a_hdr_in_payload: assert property (@(posedge clock) disable iff (reset)
      (payload_left_ff != 16'd0) |-> (hdr_cnt_ff == 3'd0 && !halted_ff))
      else $error("header count active inside record payload");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (hdr_cnt_ff <= HDR_LAST) && (hs_hdr_cnt_ff <= 3'd4))
      else $error("header counter out of range");

endmodule

### verif/tb.sv
// Self-checking testbench for tls_record_deframer: byte stream in, reports out.
// Depends on tlsd_pkg for the report layout and status codes.
// A built-in deframer predictor produces the expected reports for each accepted byte.
`timescale 1ns / 1ps

module tb import tlsd_pkg::*; ();

   localparam logic [7:0]  CT_ALERT   = 8'd21;
   localparam logic [7:0]  CT_APPDATA = 8'd23;
   localparam logic [15:0] TLS12      = 16'h0303;
   localparam int REC_HDR_LAST  = 4;
   localparam int HS_HDR_BYTES  = 4;
   localparam int DRAIN_CYCLES  = 12;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_BYTES   = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;

   tls_record_deframer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // deframer predictor state
   logic [15:0]      max_len = MAX_REC_RESET;
   logic [2:0]       hdr_cnt = '0;
   logic [7:0]       rtype = '0;
   logic [15:0]      rver = '0;
   logic [15:0]      rlen = '0;
   logic [15:0]      pay_left = '0;
   logic [23:0]      pay_head = '0;
   logic             cipher = 1'b0;
   logic             halted = 1'b0;
   logic [OFS_W-1:0] seg_ofs = '0;
   logic [OFS_W-1:0] safe_ofs = '0;
   logic [2:0]       hs_hcnt = '0;
   logic [7:0]       hs_type = '0;
   logic [23:0]      hs_left = '0;
   logic [7:0]       hs_recs = '0;

   rsp_type predicted_reports[$];
   int      reports_this_byte;

   int fail_count = 0;
   int bytes_sent = 0;
   int segments_sent = 0;
   int status_seen[6];
   bit gaps_on = 1'b1;
   logic [15:0] gen_limit = MAX_REC_RESET;

   // segment under construction: {connection_start, data_byte}
   logic [8:0] segment_bytes[$];
   logic       conn_pending = 1'b0;
   logic [7:0] hs_stream[$];

   function automatic bit framing_on();
      return rtype == CT_HANDSHAKE && !cipher;
   endfunction

   function automatic void add_report(logic [2:0] st, logic with_rec, logic [7:0] ht,
                                      logic [23:0] hl, logic re);
      rsp_type r;
      if (reports_this_byte >= 2) return;
      r.status          = st;
      r.rec_kind        = with_rec ? rtype : 8'd0;
      r.record_version  = with_rec ? rver : 16'd0;
      r.payload_len     = with_rec ? rlen : 16'd0;
      r.msg_kind        = ht;
      r.msg_len         = hl;
      r.reassembled     = re;
      r.consumed_offset = safe_ofs;
      r.last            = 1'b0;
      predicted_reports.insert(predicted_reports.size(), r);
      reports_this_byte++;
   endfunction

   function automatic void close_record();
      logic [OFS_W-1:0] rec_end;
      rec_end = seg_ofs + 1'b1;
      if (framing_on()) begin
         // record ending on a message boundary is safe to consume
         if (hs_hcnt == 0) begin
            safe_ofs = rec_end;
            hs_recs  = '0;
         end else if (hs_recs < 8'd255) begin
            hs_recs++;
         end
         add_report(ST_RECORD, 1'b1, 8'd0, 24'd0, 1'b0);
      end else if ((rtype == CT_CCS && rlen == 16'd1 && pay_head[7:0] != 8'd1) ||
                   (rtype == CT_HEARTBEAT && rlen >= 16'd3 &&
                    pay_head[15:0] > rlen - 16'd3)) begin
         add_report(ST_BAD_PAY, 1'b1, 8'd0, 24'd0, 1'b0);
         halted = 1'b1;
      end else begin
         safe_ofs = rec_end;
         if (rtype == CT_CCS && rlen == 16'd1) cipher = 1'b1;
         add_report(ST_RECORD, 1'b1, 8'd0, 24'd0, 1'b0);
      end
   endfunction

   function automatic void frame_hs_byte(logic [7:0] b);
      logic done;
      done = 1'b0;
      if (hs_hcnt == 0) begin
         hs_type = b;
         hs_left = '0;
         hs_hcnt = 3'd1;
      end else if (hs_hcnt < HS_HDR_BYTES) begin
         hs_left = {hs_left[15:0], b};
         hs_hcnt++;
         if (hs_hcnt == HS_HDR_BYTES) begin
            pay_head = hs_left;
            done = (hs_left == 0);
         end
      end else begin
         hs_left = hs_left - 1'b1;
         done = (hs_left == 0);
      end
      if (done) begin
         add_report(ST_HS_MSG, 1'b1, hs_type, pay_head, hs_recs != 0);
         hs_hcnt = '0;
      end
   endfunction

   function automatic void deframe_byte(logic [7:0] b, logic eos, logic conn);
      reports_this_byte = 0;
      if (conn) cipher = 1'b0;
      if (!halted) begin
         if (pay_left == 0) begin
            case (hdr_cnt)
               3'd0: begin
                  rtype = b;
                  rver  = '0;
                  rlen  = '0;
               end
               3'd1: rver = {b, 8'h00};
               3'd2: rver[7:0] = b;
               3'd3: rlen = {b, 8'h00};
               default: rlen[7:0] = b;
            endcase
            if (hdr_cnt < REC_HDR_LAST) begin
               hdr_cnt++;
            end else begin
               hdr_cnt = '0;
               if (rtype < CT_CCS || rtype > CT_HEARTBEAT || rver[15:8] != VER_MAJOR ||
                   rlen > max_len) begin
                  add_report(ST_MALFORMED, 1'b1, 8'd0, 24'd0, 1'b0);
                  halted = 1'b1;
               end else if (!framing_on() && hs_hcnt != 0) begin
                  add_report(ST_HS_PENDING, 1'b1, 8'd0, 24'd0, 1'b0);
                  halted = 1'b1;
               end else begin
                  pay_left = rlen;
                  if (!framing_on()) pay_head = '0;
                  if (rlen == 0) close_record();
               end
            end
         end else begin
            if (framing_on()) frame_hs_byte(b);
            else if (rlen - pay_left < 16'd3) pay_head = {pay_head[15:0], b};
            pay_left--;
            if (pay_left == 0) close_record();
         end
         if (eos && !halted) begin
            if (hdr_cnt != 0 || pay_left != 0)
               add_report(ST_PARTIAL, pay_left != 0, 8'd0, 24'd0, 1'b0);
            if (hs_hcnt != 0) add_report(ST_HS_PENDING, 1'b0, 8'd0, 24'd0, 1'b0);
         end
      end
      if (reports_this_byte > 0)
         predicted_reports[predicted_reports.size() - 1].last = 1'b1;
      if (eos) begin
         hdr_cnt = '0; rtype = '0; rver = '0; rlen = '0;
         pay_left = '0; pay_head = '0; halted = 1'b0;
         seg_ofs = '0; safe_ofs = '0;
         hs_hcnt = '0; hs_type = '0; hs_left = '0; hs_recs = '0;
      end else begin
         seg_ofs = seg_ofs + 1'b1;
      end
   endfunction

   function automatic string show_report(rsp_type r);
      return $sformatf("st=%0d ct=%h ver=%h len=%h ht=%h hl=%h re=%b ofs=%h last=%b",
                       r.status, r.rec_kind, r.record_version, r.payload_len,
                       r.msg_kind, r.msg_len, r.reassembled,
                       r.consumed_offset, r.last);
   endfunction

   task automatic flag_mismatch(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("MISMATCH (%s) at %0t", what, $realtime);
         $display("   expected %s", show_report(want));
         $display("   actual   %s", show_report(got));
      end
   endtask

   // predict on each accepted request, compare each accepted report
   always @(posedge clock) begin : report_check
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) deframe_byte(req_tdata, req_tlast, req_tuser);
         if (csr_we) max_len = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.status          = rsp_tuser;
            got.rec_kind        = rsp_tdata[7:0];
            got.record_version  = rsp_tdata[23:8];
            got.payload_len     = rsp_tdata[39:24];
            got.msg_kind        = rsp_tdata[47:40];
            got.msg_len         = rsp_tdata[71:48];
            got.reassembled     = rsp_tdata[72];
            got.consumed_offset = rsp_tdata[88:73];
            got.last            = rsp_tlast;
            if (predicted_reports.size() == 0) begin
               flag_mismatch("report with nothing expected", got, got);
            end else begin
               want = predicted_reports.pop_front();
               if (got != want || rsp_tdata[95:89] != '0)
                  flag_mismatch("field mismatch", want, got);
               else if (want.status <= ST_HS_PENDING)
                  status_seen[want.status]++;
            end
         end
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin : rsp_stall
      int stall_left;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tls_record_deframer verification failed");
      $finish;
   end

   task automatic send_byte(logic [7:0] b, logic eos, logic conn);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      req_tuser  <= conn;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_segment();
      logic [8:0] e;
      int i;
      for (i = 0; i < segment_bytes.size(); i++) begin
         e = segment_bytes[i];
         send_byte(e[7:0], i == segment_bytes.size() - 1, e[8]);
      end
      segment_bytes.delete();
      segments_sent++;
   endtask

   // hold requests until every predicted report has come out
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predicted_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_max_record_length(logic [15:0] v);
      settle();
      gen_limit = v;
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic void put_byte(logic [7:0] b);
      segment_bytes.insert(segment_bytes.size(), {conn_pending, b});
      conn_pending = 1'b0;
   endfunction

   function automatic void put_header(logic [7:0] t, logic [15:0] ver, logic [15:0] len);
      put_byte(t);
      put_byte(ver[15:8]);
      put_byte(ver[7:0]);
      put_byte(len[15:8]);
      put_byte(len[7:0]);
   endfunction

   function automatic logic [7:0] next_hs_byte();
      logic [23:0] hlen;
      int body;
      if (hs_stream.size() == 0) begin
         case ($urandom_range(0, 9))
            0: hlen = 24'($urandom);   // effectively never completes
            1: hlen = 24'd0;
            default: hlen = 24'($urandom_range(1, 12));
         endcase
         hs_stream.insert(hs_stream.size(), 8'($urandom_range(0, 255)));
         hs_stream.insert(hs_stream.size(), hlen[23:16]);
         hs_stream.insert(hs_stream.size(), hlen[15:8]);
         hs_stream.insert(hs_stream.size(), hlen[7:0]);
         body = (hlen > 24) ? 24 : int'(hlen);
         repeat (body) hs_stream.insert(hs_stream.size(), 8'($urandom_range(0, 255)));
      end
      return hs_stream.pop_front();
   endfunction

   function automatic void build_random_segment();
      int n_rec, kind, len, cut, i;
      logic [7:0]  rt;
      logic [15:0] ver, declared;
      hs_stream.delete();
      conn_pending = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24)) put_byte(8'($urandom_range(0, 255)));
         return;
      end
      n_rec = $urandom_range(1, 4);
      repeat (n_rec) begin
         kind = $urandom_range(0, 15);
         ver  = ($urandom_range(0, 3) == 0) ? {VER_MAJOR, 8'($urandom_range(0, 255))} : TLS12;
         if (kind <= 6) begin
            if ($urandom_range(0, 1) == 1 && hs_stream.size() > 0 && hs_stream.size() <= 40)
               len = hs_stream.size();
            else
               len = $urandom_range(0, 16);
            put_header(CT_HANDSHAKE, ver, 16'(len));
            repeat (len) put_byte(next_hs_byte());
         end else if (kind <= 8) begin
            len = $urandom_range(0, 20);
            put_header(CT_APPDATA, ver, 16'(len));
            repeat (len) put_byte(8'($urandom_range(0, 255)));
         end else if (kind == 9) begin
            put_header(CT_ALERT, ver, 16'd2);
            put_byte(8'($urandom_range(1, 2)));
            put_byte(8'($urandom_range(0, 255)));
         end else if (kind == 10) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
            put_header(CT_CCS, ver, 16'(len));
            if (len == 1)
               put_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd1);
            else
               repeat (len) put_byte(8'($urandom_range(0, 255)));
         end else if (kind == 11) begin
            len = $urandom_range(0, 12);
            put_header(CT_HEARTBEAT, ver, 16'(len));
            if (len >= 3) begin
               case ($urandom_range(0, 3))
                  0: declared = 16'($urandom);
                  1: declared = 16'(len - 2);
                  default: declared = 16'($urandom_range(0, len - 3));
               endcase
               put_byte(8'($urandom_range(0, 255)));
               put_byte(declared[15:8]);
               put_byte(declared[7:0]);
               repeat (len - 3) put_byte(8'($urandom_range(0, 255)));
            end else begin
               repeat (len) put_byte(8'($urandom_range(0, 255)));
            end
         end else if (kind == 12) begin
            rt = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 19))
                                              : 8'($urandom_range(25, 255));
            put_header(rt, ver, 16'($urandom_range(0, 6)));
            repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
         end else if (kind == 13) begin
            ver = 16'($urandom);
            if (ver[15:8] == VER_MAJOR) ver[15] = 1'b1;
            put_header(8'($urandom_range(20, 24)), ver, 16'($urandom_range(0, 6)));
         end else if (kind == 14) begin
            len = $urandom_range(0, 8);
            put_header(8'($urandom_range(20, 24)), ver, 16'(len));
            repeat (len) put_byte(8'($urandom_range(0, 255)));
         end else begin
            // right at or just over the length limit
            if (gen_limit <= 40) begin
               len = gen_limit + $urandom_range(0, 1);
               put_header(CT_APPDATA, ver, 16'(len));
               repeat (len) put_byte(8'($urandom_range(0, 255)));
            end else if (gen_limit != 16'hffff) begin
               put_header(CT_APPDATA, ver, 16'($urandom_range(gen_limit + 1, 65535)));
            end else begin
               put_header(CT_ALERT, ver, 16'd0);
            end
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         i = $urandom_range(0, segment_bytes.size() - 1);
         segment_bytes[i] = segment_bytes[i] | 9'h100;
      end
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, segment_bytes.size());
         while (segment_bytes.size() > cut) void'(segment_bytes.pop_back());
      end
   endfunction

   task automatic test_record_kinds();
      conn_pending = 1'b1;
      put_header(CT_ALERT, TLS12, 16'd2);
      put_byte(8'h00); put_byte(8'hff);
      // heartbeat declaring exactly length minus three
      put_header(CT_HEARTBEAT, 16'h0301, 16'd5);
      put_byte(8'h01); put_byte(8'h00); put_byte(8'h02); put_byte(8'haa); put_byte(8'h55);
      put_header(CT_HEARTBEAT, TLS12, 16'd2);
      put_byte(8'hff); put_byte(8'hff);
      put_header(CT_CCS, TLS12, 16'd1);
      put_byte(8'h01);
      // after ChangeCipherSpec handshake records are not framed
      put_header(CT_HANDSHAKE, TLS12, 16'd3);
      put_byte(8'h01); put_byte(8'h02); put_byte(8'h03);
      put_header(CT_APPDATA, 16'h03ff, 16'd0);
      send_segment();
   endtask

   task automatic test_handshake_framing();
      conn_pending = 1'b1;
      put_header(CT_HANDSHAKE, TLS12, 16'd6);
      put_byte(8'h01); put_byte(8'h00); put_byte(8'h00); put_byte(8'h02);
      put_byte(8'haa); put_byte(8'hbb);
      // message split over two records
      put_header(CT_HANDSHAKE, TLS12, 16'd3);
      put_byte(8'h02); put_byte(8'h00); put_byte(8'h00);
      put_header(CT_HANDSHAKE, TLS12, 16'd4);
      put_byte(8'h03); put_byte(8'h11); put_byte(8'h22); put_byte(8'h33);
      put_header(CT_HANDSHAKE, TLS12, 16'd4);
      put_byte(8'h0f); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
      put_header(CT_HANDSHAKE, TLS12, 16'd0);
      send_segment();
   endtask

   task automatic test_bad_header();
      put_header(8'd19, TLS12, 16'd0);
      put_byte(8'h16); put_byte(8'h03);   // ignored after the stop
      send_segment();
      put_header(8'd25, TLS12, 16'd0);
      send_segment();
      put_header(CT_APPDATA, 16'h0203, 16'd0);
      put_byte(8'h00);
      send_segment();
      put_header(CT_APPDATA, TLS12, MAX_REC_RESET + 16'd1);
      put_byte(8'h00);
      send_segment();
   endtask

   task automatic test_bad_payload();
      put_header(CT_CCS, TLS12, 16'd1);
      put_byte(8'h00); put_byte(8'h17);
      send_segment();
      put_header(CT_HEARTBEAT, TLS12, 16'd4);
      put_byte(8'h01); put_byte(8'h00); put_byte(8'h02); put_byte(8'hff);
      send_segment();
   endtask

   task automatic test_pending_message();
      conn_pending = 1'b1;
      put_header(CT_HANDSHAKE, TLS12, 16'd2);
      put_byte(8'h01); put_byte(8'h00);
      put_header(CT_ALERT, TLS12, 16'd2);
      put_byte(8'h02); put_byte(8'h28);
      send_segment();
      put_header(CT_HANDSHAKE, TLS12, 16'd2);
      put_byte(8'h01); put_byte(8'h00);
      send_segment();
   endtask

   task automatic test_truncation();
      put_byte(CT_APPDATA); put_byte(8'h03);
      send_segment();
      put_header(CT_APPDATA, TLS12, 16'd5);
      put_byte(8'h01); put_byte(8'h02);
      send_segment();
      // message completes on the cut byte
      put_header(CT_HANDSHAKE, TLS12, 16'd10);
      put_byte(8'h01); put_byte(8'h00); put_byte(8'h00); put_byte(8'h01); put_byte(8'haa);
      send_segment();
      put_header(CT_HANDSHAKE, TLS12, 16'd10);
      put_byte(8'h01); put_byte(8'h00); put_byte(8'h00);
      send_segment();
   endtask

   task automatic test_conn_start_mid_record();
      put_header(CT_CCS, TLS12, 16'd1);
      put_byte(8'h01);
      put_header(CT_HANDSHAKE, TLS12, 16'd5);
      put_byte(8'h09);
      conn_pending = 1'b1;   // framing resumes for the rest of this record
      put_byte(8'h01); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
      send_segment();
   endtask

   task automatic test_length_limit();
      set_max_record_length(16'd0);
      put_header(CT_APPDATA, TLS12, 16'd0);
      put_header(CT_APPDATA, TLS12, 16'd1);
      put_byte(8'h5a);
      send_segment();
      set_max_record_length(16'd5);
      put_header(CT_ALERT, TLS12, 16'd5);
      repeat (5) put_byte(8'($urandom_range(0, 255)));
      put_header(CT_ALERT, TLS12, 16'd6);
      send_segment();
   endtask

   task automatic test_random_traffic();
      int phase, mark;
      logic [15:0] lim;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: lim = MAX_REC_RESET;
            1: lim = 16'd12;
            2: lim = 16'hffff;
            3: lim = 16'($urandom);
            4: lim = 16'd0;
            default: lim = 16'd24;
         endcase
         gaps_on = (phase != 5);
         set_max_record_length(lim);
         mark = bytes_sent;
         while (bytes_sent - mark < PHASE_BYTES) begin
            build_random_segment();
            send_segment();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_record_kinds();
      test_handshake_framing();
      test_bad_header();
      test_bad_payload();
      test_pending_message();
      test_truncation();
      test_conn_start_mid_record();
      test_length_limit();
      test_random_traffic();
      settle();
      if (predicted_reports.size() != 0) fail_count++;
      $display("Sent %0d bytes in %0d segments over several length limits.",
               bytes_sent, segments_sent);
      $display("Reports matched: rec %0d, msg %0d, malformed %0d, bad %0d, partial %0d, pend %0d",
               status_seen[ST_RECORD], status_seen[ST_HS_MSG], status_seen[ST_MALFORMED],
               status_seen[ST_BAD_PAY], status_seen[ST_PARTIAL], status_seen[ST_HS_PENDING]);
      if (fail_count == 0)
         $display("tls_record_deframer verification clean");
      else
         $display("tls_record_deframer verification failed");
      $finish;
   end

endmodule
